>>> hdl/lsf_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and filter coefficients for the luma sub-sample filter.
package lsf_pkg;

    typedef struct packed {
        logic [7:0] ref_sample;
        logic       block_start;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_sample;
        logic       row_end;
    } out_word_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAC_POS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PU_WIDTH  = 2'd2;

    localparam logic [1:0] FRAC_POS_RESET = 2'd2;
    localparam logic       DIR_HORIZONTAL = 1'b0;
    localparam logic       DIR_VERTICAL   = 1'b1;
    localparam logic [6:0] PU_WIDTH_RESET = 7'd16;

    localparam int TAP_W = 7;

    // rows: fractional position 0..3; position 0 is a plain copy of the second tap
    localparam logic signed [TAP_W-1:0] TAP_TABLE [4][4] = '{
        '{ 7'sd0,  7'sd32, 7'sd0,  7'sd0  },
        '{ -7'sd1, 7'sd25, 7'sd9,  -7'sd1 },
        '{ -7'sd2, 7'sd18, 7'sd18, -7'sd2 },
        '{ -7'sd1, 7'sd9,  7'sd25, -7'sd1 }
    };

    localparam logic signed [15:0] ROUND_BIAS = 16'sh0010;
    localparam int                 ROUND_SHIFT = 5;

endpackage

>>> hdl/lsf_tap_filter.sv
`timescale 1ns / 1ps
// Four-tap weighted sum with rounding, shift and clamp to 8 bits.
module lsf_tap_filter (
    input  logic [1:0] frac_pos,
    input  logic [7:0] tap_a,
    input  logic [7:0] tap_b,
    input  logic [7:0] tap_c,
    input  logic [7:0] tap_d,
    output logic [7:0] out_sample
);
    import lsf_pkg::*;

    logic signed [15:0] prod_a;
    logic signed [15:0] prod_b;
    logic signed [15:0] prod_c;
    logic signed [15:0] prod_d;
    logic signed [15:0] sum;
    logic signed [15:0] shifted;

    always_comb
    begin
        prod_a  = 16'(TAP_TABLE[frac_pos][0]) * 16'(signed'({1'b0, tap_a}));
        prod_b  = 16'(TAP_TABLE[frac_pos][1]) * 16'(signed'({1'b0, tap_b}));
        prod_c  = 16'(TAP_TABLE[frac_pos][2]) * 16'(signed'({1'b0, tap_c}));
        prod_d  = 16'(TAP_TABLE[frac_pos][3]) * 16'(signed'({1'b0, tap_d}));
        sum     = prod_a + prod_b + prod_c + prod_d + ROUND_BIAS;
        shifted = sum >>> ROUND_SHIFT;
        if (shifted < 16'sd0)
        begin
            out_sample = 8'd0;
        end
        else if (shifted > 16'sd255)
        begin
            out_sample = 8'd255;
        end
        else
        begin
            out_sample = shifted[7:0];
        end
    end

endmodule

>>> hdl/luma_subpel_four_tap_filter.sv
`timescale 1ns / 1ps
// Top level of the streaming four-tap luma sub-sample interpolation filter.
// Stage 1 holds an accepted word; any result goes to the output register. Throughput: one
// input word per cycle unless in_stall; the line store is read at accept and, in vertical
// mode, written as it leaves stage 1, with write-to-read forwarding for a repeated column.
// Reset: rst_n (async, active low) clears counters, tap window, pipeline valids and
// restores frac_pos 2, horizontal mode, pu_width 16; the line store is not cleared.
module luma_subpel_four_tap_filter #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lsf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lsf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  lsf_pkg::in_word_t                  in_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output lsf_pkg::out_word_t                 out_word
);
    import lsf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 3);
    localparam int AW = $clog2(MAX_WIDTH);

    // configuration
    logic [1:0] frac_pos_reg;
    logic       direction_reg;
    logic [6:0] pu_width_reg;

    // stream state
    logic [23:0]   win_reg;
    logic [CW-1:0] col_reg;
    logic [1:0]    rc_reg;

    // stage 1
    logic          s1_valid_reg;
    logic          s1_emit_reg;
    logic          s1_dir_reg;
    logic          s1_last_reg;
    logic [AW-1:0] s1_idx_reg;
    logic [7:0]    s1_sample_reg;
    logic [7:0]    s1_a_reg;
    logic [7:0]    s1_b_reg;
    logic [7:0]    s1_c_reg;
    logic [23:0]   rd_reg;

    // output
    logic      out_valid_reg;
    out_word_t out_word_reg;

    logic [23:0] line_mem [MAX_WIDTH];

    logic          accept;
    logic          advance;
    logic          out_load;
    logic [CW-1:0] width_eff;
    logic [CW-1:0] col_base;
    logic [23:0]   win_base;
    logic [1:0]    rc_base;
    logic          last_next;
    logic          emit_next;
    logic [AW-1:0] idx_next;
    logic [1:0]    rc_next;
    logic [23:0]   win_next;
    logic [CW-1:0] col_next;
    logic          mem_we;
    logic [23:0]   mem_wdata;
    logic [7:0]    tap_a;
    logic [7:0]    tap_b;
    logic [7:0]    tap_c;
    logic [7:0]    filt_sample;

    assign advance  = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign out_load = advance && s1_emit_reg;
    assign mem_we   = advance && (s1_dir_reg == DIR_VERTICAL);
    assign mem_wdata = {rd_reg[15:0], s1_sample_reg};

    always_comb
    begin
        if (pu_width_reg == 7'd0)
        begin
            width_eff = CW'(1);
        end
        else if ({1'b0, pu_width_reg} > 8'(MAX_WIDTH))
        begin
            width_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = CW'(pu_width_reg);
        end

        col_base = in_word.block_start ? '0 : col_reg;
        win_base = in_word.block_start ? '0 : win_reg;
        rc_base  = in_word.block_start ? 2'd0 : rc_reg;

        if (col_base < CW'(MAX_WIDTH))
        begin
            idx_next = AW'(col_base);
        end
        else
        begin
            idx_next = AW'(MAX_WIDTH - 1);
        end

        win_next = win_base;
        rc_next  = rc_base;
        if (direction_reg == DIR_HORIZONTAL)
        begin
            last_next = {1'b0, col_base} >= ({1'b0, width_eff} + (CW + 1)'(2));
            emit_next = col_base >= CW'(3);
            win_next  = {win_base[15:0], in_word.ref_sample};
        end
        else
        begin
            last_next = {1'b0, col_base} >= ({1'b0, width_eff} - (CW + 1)'(1));
            emit_next = rc_base == 2'd3;
            if (last_next && rc_base != 2'd3)
            begin
                rc_next = rc_base + 2'd1;
            end
        end

        col_next = last_next ? '0 : col_base + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_pos_reg  <= FRAC_POS_RESET;
            direction_reg <= DIR_HORIZONTAL;
            pu_width_reg  <= PU_WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_FRAC_POS:  frac_pos_reg  <= cfg_wdata[1:0];
                CFG_DIRECTION: direction_reg <= cfg_wdata[0];
                CFG_PU_WIDTH:  pu_width_reg  <= cfg_wdata[6:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            col_reg       <= '0;
            rc_reg        <= 2'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                win_reg <= win_next;
                col_reg <= col_next;
                rc_reg  <= rc_next;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg   <= emit_next;
            s1_dir_reg    <= direction_reg;
            s1_last_reg   <= last_next;
            s1_idx_reg    <= idx_next;
            s1_sample_reg <= in_word.ref_sample;
            s1_a_reg      <= win_base[23:16];
            s1_b_reg      <= win_base[15:8];
            s1_c_reg      <= win_base[7:0];
        end
        if (out_load)
        begin
            out_word_reg.out_sample <= filt_sample;
            out_word_reg.row_end    <= s1_last_reg;
        end
    end

    // line store: one word per column holds the three earlier rows, oldest in the top byte
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[s1_idx_reg] <= mem_wdata;
        end
        if (accept)
        begin
            if (mem_we && s1_idx_reg == idx_next)
            begin
                rd_reg <= mem_wdata;
            end
            else
            begin
                rd_reg <= line_mem[idx_next];
            end
        end
    end

    assign tap_a = (s1_dir_reg == DIR_VERTICAL) ? rd_reg[23:16] : s1_a_reg;
    assign tap_b = (s1_dir_reg == DIR_VERTICAL) ? rd_reg[15:8]  : s1_b_reg;
    assign tap_c = (s1_dir_reg == DIR_VERTICAL) ? rd_reg[7:0]   : s1_c_reg;

    lsf_tap_filter u_tap_filter (
        .frac_pos   (frac_pos_reg),
        .tap_a      (tap_a),
        .tap_b      (tap_b),
        .tap_c      (tap_c),
        .tap_d      (s1_sample_reg),
        .out_sample (filt_sample)
    );

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_emit_reg && out_valid_reg))
        else $error("input stalled without a blocked result");

    a_emit_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emit_reg && !in_stall) |=> out_valid)
        else $error("filtered word lost between stages");

    a_col_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= CW'(MAX_WIDTH + 2))
        else $error("column count past longest row");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && !out_load) |=> (out_valid && $stable(out_word)))
        else $error("stalled result changed");

endmodule

>>> sim/tb_luma_subpel_four_tap_filter.sv
`timescale 1ns / 1ps
// Self-checking testbench for the four-tap luma sub-sample filter: random streams, scoreboard.
module tb_luma_subpel_four_tap_filter;

    import lsf_pkg::*;

    localparam int MAX_W       = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_WORDS = 1500;

    localparam logic [1:0] FRAC_FULL          = 2'd0;
    localparam logic [1:0] FRAC_QUARTER       = 2'd1;
    localparam logic [1:0] FRAC_HALF          = 2'd2;
    localparam logic [1:0] FRAC_THREE_QUARTER = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   in_valid;
    logic                   in_stall;
    in_word_t               in_word;
    logic                   out_valid;
    logic                   out_stall;
    out_word_t              out_word;

    // filter state mirrored by the testbench
    logic [1:0]  cur_frac;
    logic        cur_dir;
    logic [6:0]  cur_width;
    logic [23:0] pix_window;
    int          col_pos;
    int          rows_done;
    logic [7:0]  line_mem [3*MAX_W];

    out_word_t   expected_pixels [$];
    out_word_t   oldest_pixel;

    int err_cnt;
    int cycle_count;
    int words_sent;
    int burst_left;
    bit no_gap;
    bit steady;
    bit hold_request;
    int hold_left;
    int stall_mode;
    int stall_timer;

    luma_subpel_four_tap_filter #(
        .MAX_WIDTH (MAX_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_cnt++;
    endtask

    function automatic int clamp_width(input logic [6:0] w);
        int ew;
        ew = int'(w);
        if (ew == 0)
            ew = 1;
        if (ew > MAX_W)
            ew = MAX_W;
        return ew;
    endfunction

    function automatic logic [7:0] interp_pixel(input logic [1:0] frac,
                                                input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c, input logic [7:0] d);
        int t0, t1, t2, t3, sum, q;
        case (frac)
            FRAC_QUARTER:
            begin
                t0 = -1; t1 = 25; t2 = 9;  t3 = -1;
            end
            FRAC_HALF:
            begin
                t0 = -2; t1 = 18; t2 = 18; t3 = -2;
            end
            FRAC_THREE_QUARTER:
            begin
                t0 = -1; t1 = 9;  t2 = 25; t3 = -1;
            end
            default:
            begin
                t0 = 0;  t1 = 32; t2 = 0;  t3 = 0;
            end
        endcase
        sum = t0 * int'(a) + t1 * int'(b) + t2 * int'(c) + t3 * int'(d);
        q = (sum + 16) >>> 5;
        if (q < 0)
            q = 0;
        if (q > 255)
            q = 255;
        return q[7:0];
    endfunction

    // advance the mirrored filter by one accepted word, queue any output pixel
    task automatic predict_pixel(input logic [7:0] s, input logic bs);
        int        w, c, idx;
        bit        last;
        logic [7:0] r0, r1, r2;
        out_word_t px;
        w = clamp_width(cur_width);
        c = col_pos;
        if (bs)
        begin
            pix_window = '0;
            col_pos    = 0;
            rows_done  = 0;
            c          = 0;
        end
        if (cur_dir == DIR_HORIZONTAL)
        begin
            last = (c >= w + 2);
            if (c >= 3)
            begin
                px.out_sample = interp_pixel(cur_frac, pix_window[23:16], pix_window[15:8],
                                             pix_window[7:0], s);
                px.row_end    = last;
                expected_pixels.push_back(px);
            end
            pix_window = {pix_window[15:0], s};
        end
        else
        begin
            idx  = (c < MAX_W) ? c : MAX_W - 1;
            r0   = line_mem[idx];
            r1   = line_mem[MAX_W + idx];
            r2   = line_mem[2*MAX_W + idx];
            last = (c >= w - 1);
            if (rows_done >= 3)
            begin
                px.out_sample = interp_pixel(cur_frac, r0, r1, r2, s);
                px.row_end    = last;
                expected_pixels.push_back(px);
            end
            line_mem[idx]           = r1;
            line_mem[MAX_W + idx]   = r2;
            line_mem[2*MAX_W + idx] = s;
            if (last && rows_done < 3)
                rows_done++;
        end
        col_pos = last ? 0 : ((c + 1) & 8'hFF);
    endtask

    // offer one word; valid stays high into the next word unless a gap is due
    task automatic send_word(input logic [7:0] s, input logic bs);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (steady || no_gap) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= '{ref_sample: s, block_start: bs};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        predict_pixel(s, bs);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [6:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_FRAC_POS:  cur_frac  = value[1:0];
            CFG_DIRECTION: cur_dir   = value[0];
            CFG_PU_WIDTH:  cur_width = value;
            default: ;
        endcase
    endtask

    // one block of rows with random content; noisy blocks scatter block starts,
    // broken blocks stop early
    task automatic send_block(input int rows, input int row_len, input bit noisy);
        int  total, i;
        logic bs;
        total = rows * row_len;
        if ($urandom_range(0, 7) == 0)
            total = $urandom_range(1, total);
        for (i = 0; i < total; i++)
        begin
            if (i == 0)
                bs = 1'b1;
            else if (noisy)
                bs = ($urandom_range(0, 3) == 0);
            else
                bs = ($urandom_range(0, 99) == 0);
            send_word(8'($urandom_range(0, 255)), bs);
        end
    endtask

    task automatic test_reset_defaults();
        int i;
        // period-four 0/255 pattern drives both clamp limits
        for (i = 0; i < 19; i++)
            send_word((i % 4 == 1 || i % 4 == 2) ? 8'hFF : 8'h00, i == 0);
        wait_drained();
    endtask

    task automatic test_block_restart();
        int i;
        for (i = 0; i < 6; i++)
            send_word(8'($urandom_range(0, 255)), i == 0 || i == 3);
        wait_drained();
    endtask

    task automatic test_backpressure();
        int i;
        cfg_write(CFG_FRAC_POS, {5'd0, FRAC_QUARTER});
        cfg_write(CFG_PU_WIDTH, 7'd8);
        no_gap       = 1'b1;
        hold_request = 1'b1;
        for (i = 0; i < 60; i++)
            send_word(8'($urandom_range(0, 255)), i == 0);
        no_gap = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_phases();
        int phase, start_words, blocks, b, rows, ew;
        logic [1:0] frac;
        logic       dir;
        logic [6:0] width;
        phase       = 0;
        start_words = words_sent;
        while (words_sent - start_words < RANDOM_WORDS)
        begin
            case (phase)
                0:
                begin
                    frac = FRAC_FULL;          dir = DIR_HORIZONTAL; width = 7'd0;
                end
                1:
                begin
                    frac = FRAC_THREE_QUARTER; dir = DIR_VERTICAL;   width = 7'd1;
                end
                2:
                begin
                    frac = FRAC_QUARTER;       dir = DIR_HORIZONTAL; width = 7'd127;
                end
                3:
                begin
                    frac = FRAC_HALF;          dir = DIR_VERTICAL;   width = 7'd64;
                end
                4:
                begin
                    frac = FRAC_QUARTER;       dir = DIR_VERTICAL;   width = 7'd65;
                end
                5:
                begin
                    frac = FRAC_THREE_QUARTER; dir = DIR_HORIZONTAL; width = 7'd8;
                end
                6:
                begin
                    frac = FRAC_FULL;          dir = DIR_VERTICAL;   width = 7'd0;
                end
                default:
                begin
                    frac = 2'($urandom_range(0, 3));
                    dir  = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 9))
                        0:       width = 7'd0;
                        1:       width = 7'($urandom_range(57, 127));
                        2:       width = 7'(8 * $urandom_range(1, 2));
                        default: width = 7'($urandom_range(1, 20));
                    endcase
                end
            endcase
            cfg_write(CFG_FRAC_POS, {5'd0, frac});
            cfg_write(CFG_DIRECTION, {6'd0, dir});
            cfg_write(CFG_PU_WIDTH, width);
            steady = ($urandom_range(0, 4) == 0);
            ew     = clamp_width(width);
            blocks = (ew > 24) ? 1 : $urandom_range(1, 3);
            for (b = 0; b < blocks; b++)
            begin
                if (dir == DIR_HORIZONTAL)
                begin
                    rows = (ew > 24) ? $urandom_range(1, 2) : $urandom_range(1, 4);
                    send_block(rows, ew + 3, $urandom_range(0, 9) == 0);
                end
                else
                begin
                    rows = (ew > 24) ? 4 : $urandom_range(4, 6);
                    send_block(rows, ew, $urandom_range(0, 9) == 0);
                end
            end
            steady = 1'b0;
            wait_drained();
            phase++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            stall_timer++;
            if (stall_timer >= 64)
            begin
                stall_timer = 0;
                stall_mode  = $urandom_range(0, 3);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (steady)
                out_stall <= 1'b0;
            else
            begin
                case (stall_mode)
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    3:       out_stall <= stall_timer[0];
                    default: out_stall <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("unexpected word %h", out_word));
            else
            begin
                oldest_pixel = expected_pixels.pop_front();
                if (out_word.out_sample !== oldest_pixel.out_sample)
                    report_mismatch($sformatf("out_sample got %0d exp %0d",
                                              out_word.out_sample, oldest_pixel.out_sample));
                if (out_word.row_end !== oldest_pixel.row_end)
                    report_mismatch($sformatf("row_end got %b exp %b",
                                              out_word.row_end, oldest_pixel.row_end));
            end
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        in_word      = '0;
        out_stall    = 1'b0;
        err_cnt      = 0;
        cycle_count  = 0;
        words_sent   = 0;
        burst_left   = 0;
        no_gap       = 1'b0;
        steady       = 1'b0;
        hold_request = 1'b0;
        hold_left    = 0;
        stall_mode   = 0;
        stall_timer  = 0;
        cur_frac     = FRAC_POS_RESET;
        cur_dir      = DIR_HORIZONTAL;
        cur_width    = PU_WIDTH_RESET;
        pix_window   = '0;
        col_pos      = 0;
        rows_done    = 0;
        for (int k = 0; k < 3*MAX_W; k++)
            line_mem[k] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_block_restart();
        test_backpressure();
        test_random_phases();

        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", expected_pixels.size()));
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
